// File: src/sha256_pkg.sv
// sha256_pkg: shared constants, types and round functions of the sha-256 engine
// no dependencies
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWds  = 16;

  localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

  // commands from controller to datapath
  typedef struct packed {
    logic load_word;   // write in_word into buffer at wpos
    logic word_sel_pad;// word source: 1 = pad/len word chosen by pad_kind
    logic start_blk;   // copy hash into working vars
    logic round_en;    // run one round
    logic finish_blk;  // fold working vars into hash
    logic reset_msg;   // back to initial hash
    logic [1:0] pad_kind; // which pad word
    logic [5:0] round;
  } sha_cmd_t;

  localparam logic [1:0] PadZero = 2'd0;
  localparam logic [1:0] PadLenH = 2'd1;
  localparam logic [1:0] PadLenL = 2'd2;
  localparam logic [1:0] PadData = 2'd3;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
    logic [WordW-1:0] k [Rounds];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

  function automatic logic [WordW-1:0] init_hash(input logic [2:0] i);
    logic [WordW-1:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    init_hash = h[i];
  endfunction

endpackage

// File: src/sha256_dp.sv
// sha256_dp: message buffer, rolling schedule, round logic and hash registers
// depends on sha256_pkg
module sha256_dp (
  input  logic                        clk,
  input  sha256_pkg::sha_cmd_t        cmd,
  input  logic [3:0]                  wpos,
  input  logic [31:0]                 in_word,
  input  logic [63:0]                 bit_len,
  input  logic [2:0]                  out_sel,
  output logic [31:0]                 digest
);
  import sha256_pkg::*;

  logic [WordW-1:0] w_r [BlkWds];
  logic [WordW-1:0] h_r [8];
  logic [WordW-1:0] v_r [8];
  logic [WordW-1:0] wr_word;
  logic [WordW-1:0] w_cur, w_new, s0, s1, big0, big1, ch, maj, t1, t2;

  // source of a buffer write
  always_comb begin
    case (cmd.pad_kind)
      PadZero: wr_word = '0;
      PadLenH: wr_word = bit_len[63:32];
      PadLenL: wr_word = bit_len[31:0];
      default: wr_word = in_word;
    endcase
    if (!cmd.word_sel_pad) wr_word = in_word;
  end

  // rolling 16-word schedule: w_r[0] is the word of this round
  assign s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = s1 + w_r[9] + s0 + w_r[0];
  assign w_cur = w_r[0];

  // round function
  assign big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1   = v_r[7] + big1 + ch + round_k(cmd.round) + w_cur;
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      w_r[wpos] <= wr_word;
    end else if (cmd.round_en) begin
      for (int i = 0; i < BlkWds - 1; i++) w_r[i] <= w_r[i+1];
      w_r[BlkWds-1] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.start_blk) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // hash words
  always_ff @(posedge clk) begin
    if (cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else if (cmd.finish_blk) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  assign digest = h_r[out_sel];
endmodule

// File: src/sha256_ctrl.sv
// sha256_ctrl: sequencer for word intake, padding, rounds and digest output
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_count,
  input  logic                  in_last,
  input  logic [31:0]           in_data,
  output logic [31:0]           word_out,
  output logic [63:0]           bit_len,
  output logic [3:0]            wpos,
  output sha256_pkg::sha_cmd_t  cmd,
  output logic [2:0]            out_sel,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_last
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FINISH, S_PAD, S_OUT, S_RESET
  } state_t;

  state_t      state_r;
  logic [3:0]  wpos_r;
  logic [5:0]  round_r;
  logic [63:0] len_r;
  logic        pad_r;      // in padding phase
  logic        extra_r;    // trailing 0x80 still to write
  logic        spill_r;    // length words do not fit in the current block
  logic        lenw_r;     // length words written, last block of the message
  logic [2:0]  osel_r;
  logic [31:0] word_r;
  logic [2:0]  cnt;
  logic [31:0] keep, marked;
  logic        acc;

  assign cnt = (in_count > 3'd4) ? 3'd4 : in_count;
  always_comb begin
    case (cnt)
      3'd0:    keep = 32'h0000_0000;
      3'd1:    keep = 32'hff00_0000;
      3'd2:    keep = 32'hffff_0000;
      3'd3:    keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;
    endcase
    marked = (in_data & keep) | ((cnt == 3'd4) ? 32'h0 : (PadWord >> {cnt, 3'b000}));
  end

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign wpos      = wpos_r;
  assign bit_len   = len_r;
  assign word_out  = acc ? (in_last ? marked : in_data) : word_r;
  assign out_sel   = osel_r;
  assign out_tvalid = (state_r == S_OUT);
  assign out_last  = (osel_r == 3'd7);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.round = round_r;
    cmd.load_word = acc || (state_r == S_PAD);
    cmd.word_sel_pad = (state_r == S_PAD);
    cmd.pad_kind = PadData;
    if (state_r == S_PAD) begin
      if (extra_r)                          cmd.pad_kind = PadData;
      else if (!spill_r && wpos_r == 4'd14) cmd.pad_kind = PadLenH;
      else if (!spill_r && wpos_r == 4'd15) cmd.pad_kind = PadLenL;
      else                                  cmd.pad_kind = PadZero;
    end
    cmd.start_blk  = (state_r == S_START);
    cmd.round_en   = (state_r == S_ROUND);
    cmd.finish_blk = (state_r == S_FINISH);
    cmd.reset_msg  = !rst_n || (state_r == S_RESET);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wpos_r <= '0; round_r <= '0; len_r <= '0;
      pad_r <= 1'b0; extra_r <= 1'b0; osel_r <= '0; word_r <= '0;
      spill_r <= 1'b0; lenw_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (acc) begin
          wpos_r <= wpos_r + 4'd1;
          if (in_last) begin
            len_r   <= len_r + {58'd0, cnt, 3'd0};
            pad_r   <= 1'b1;
            extra_r <= (cnt == 3'd4);
            word_r  <= PadWord;
            // 0x80 marker lands at word 14 or 15: length goes in one more block
            spill_r <= (cnt == 3'd4) ? (wpos_r inside {4'd13, 4'd14})
                                     : (wpos_r inside {4'd14, 4'd15});
          end else begin
            len_r <= len_r + 64'd32;
          end
          if (wpos_r == 4'd15)  state_r <= S_START;
          else if (in_last)     state_r <= S_PAD;
        end
        S_PAD: begin
          extra_r <= 1'b0;
          wpos_r  <= wpos_r + 4'd1;
          if (cmd.pad_kind == PadLenL) lenw_r <= 1'b1;
          if (wpos_r == 4'd15) state_r <= S_START;
        end
        S_START: begin round_r <= '0; state_r <= S_ROUND; end
        S_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) state_r <= S_FINISH;
        end
        S_FINISH: begin
          spill_r <= 1'b0;
          if (!pad_r)      state_r <= S_IDLE;
          else if (lenw_r) state_r <= S_OUT;
          else             state_r <= S_PAD;
        end
        S_OUT: if (out_tready) begin
          osel_r <= osel_r + 3'd1;
          if (osel_r == 3'd7) state_r <= S_RESET;
        end
        S_RESET: begin
          wpos_r <= '0; len_r <= '0; pad_r <= 1'b0; extra_r <= 1'b0;
          spill_r <= 1'b0; lenw_r <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/sha256_message_digest.sv
// sha256_message_digest: top level of the sha-256 engine
// depends on sha256_pkg, sha256_ctrl, sha256_dp
//
// usage:
//   input stream carries big-endian 32-bit message words; in_tlast closes the
//   message and in_tuser gives the valid leading bytes (0..4) of that word.
//   words are taken one per cycle while in_tready is high; every 16th word starts a
//   block: a start step, 64 rounds at one per cycle and a fold step, all run by
//   the single shared round unit, which holds off intake meanwhile.
//   after the final word the controller writes padding and length words, one
//   per cycle, and runs one or two more blocks.
//   the digest leaves as eight transfers, word 0 first, out_tlast on word 7,
//   then a reset step reloads the initial hash for the next message.
//   a stalled receiver holds the current digest word until taken.
//   in_tready is low during compression, padding, digest output and reload.
//   synchronous reset clears the controller and loads the initial hash.
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // data_word
  input  logic [2:0]  in_tuser,  // byte_count
  input  logic        in_tlast,  // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // digest_word, word_index, zero fill
  output logic        out_tlast  // last_word
);
  import sha256_pkg::*;

  sha_cmd_t    cmd;
  logic [31:0] word, digest;
  logic [63:0] bit_len;
  logic [3:0]  wpos;
  logic [2:0]  sel;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_count(in_tuser), .in_last(in_tlast),
    .in_data(in_tdata), .word_out(word), .bit_len, .wpos, .cmd, .out_sel(sel),
    .out_tvalid, .out_tready, .out_last(out_tlast)
  );

  sha256_dp u_dp (
    .clk, .cmd, .wpos, .in_word(word), .bit_len, .out_sel(sel), .digest
  );

  assign out_tdata = {5'd0, sel, digest};
endmodule

// File: src/sha256_chk.sv
// sha256_chk: port-level checks of the sha-256 engine, bound to the top level
// depends on sha256_message_digest ports only
module sha256_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);
  // no intake while the digest is being sent
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("intake during output");
  // tlast only on word index seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd7))) else $error("bad tlast");
  // index steps by one after each transfer
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
    out_tdata[34:32] == $past(out_tdata[34:32]) + 3'd1) else $error("index skip");
  // stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("drop");
endmodule

bind sha256_message_digest sha256_chk u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

// File: tb/sv/tb.sv
// tb: self-checking testbench for sha256_message_digest
// holds a sha-256 digest predictor in a scoreboard class; depends on sha256_pkg and the rtl
`timescale 1ns / 1ps

module tb;
  import sha256_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  // digest predictor and store of expected digest words
  class digest_board;
    logic [31:0]  hash_q [8];
    logic [31:0]  blk_q [16];
    int unsigned  fill_q;
    logic [63:0]  bit_len_q;
    digest_item_t pending_q [$];
    int unsigned  err_cnt;

    function void clear_msg();
      hash_q = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill_q = 0;
      bit_len_q = '0;
    endfunction

    function new();
      err_cnt = 0;
      clear_msg();
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void run_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] k [64];
      logic [31:0] t1, t2;
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++) w[i] = blk_q[i];
      for (int i = 16; i < 64; i++)
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hash_q[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_q[i] += v[i];
    endfunction

    function void add_word(logic [31:0] x);
      blk_q[fill_q] = x;
      fill_q++;
      if (fill_q == 16) begin
        run_block();
        fill_q = 0;
      end
    endfunction

    // note an accepted input transfer
    function void note_input(logic [31:0] data, logic [2:0] cnt, logic eom);
      int unsigned n;
      logic [31:0] keep;
      digest_item_t it;
      if (!eom) begin
        add_word(data);
        bit_len_q += 32;
        return;
      end
      n = (cnt > 4) ? 4 : cnt;
      bit_len_q += n * 8;
      if (n == 4) begin
        add_word(data);
        add_word(PadWord);
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
        add_word((data & keep) | (32'h80 << (24 - 8 * n)));
      end
      while (fill_q != 14) add_word(32'h0);
      add_word(bit_len_q[63:32]);
      add_word(bit_len_q[31:0]);
      for (int i = 0; i < 8; i++) begin
        it.word = hash_q[i];
        it.index = i[2:0];
        it.last = (i == 7);
        pending_q.push_back(it);
      end
      clear_msg();
    endfunction

    // compare an accepted result transfer with the oldest expectation
    function void check_output(logic [31:0] word, logic [2:0] idx, logic last, logic [4:0] pad);
      digest_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected digest word: expected none, actual %h", $time, word);
        err_cnt++;
        return;
      end
      e = pending_q.pop_front();
      if (word !== e.word) begin
        $display("%0t digest_word: expected %h, actual %h", $time, e.word, word);
        err_cnt++;
      end
      if (idx !== e.index) begin
        $display("%0t word_index: expected %0d, actual %0d", $time, e.index, idx);
        err_cnt++;
      end
      if (last !== e.last) begin
        $display("%0t last_word: expected %0d, actual %0d", $time, e.last, last);
        err_cnt++;
      end
      if (pad !== 5'h0) begin
        $display("%0t zero fill: expected 0, actual %h", $time, pad);
        err_cnt++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  digest_board board = new();
  bit          hold_off = 1'b0;
  bit          rx_done = 1'b0;

  always #1 clk = ~clk;

  sha256_message_digest dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0) || rx_done;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_output(out_tdata[31:0], out_tdata[34:32], out_tlast, out_tdata[39:35]);
  end

  int unsigned burst_left = 0;

  // send one word; gaps come between random bursts
  task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic eom);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= data;
    in_tuser <= cnt;
    in_tlast <= eom;
    do @(posedge clk); while (!in_tready);
    board.note_input(data, cnt, eom);
  endtask

  // message of nwords full words then a final word of cnt bytes
  task automatic send_msg(int nwords, logic [2:0] cnt, logic [31:0] fin);
    for (int i = 0; i < nwords; i++) send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(fin, cnt, 1'b1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  int sent;
  int nw;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, every final byte count, extremes
    send_msg(0, 3'd0, 32'hffffffff);
    for (int c = 0; c < 8; c++) send_msg(0, c[2:0], 32'hffffffff);
    send_msg(0, 3'd4, 32'h0);
    send_msg(1, 3'd2, 32'ha5a5a5a5);
    // final lands where padding spills into a second block
    send_msg(13, 3'd4, 32'h12345678);
    send_msg(14, 3'd0, 32'h0);
    // pause until every digest has come out
    drain();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_msg(3, 3'd1, $urandom());
        send_msg(2, 3'd3, $urandom());
        send_msg(20, 3'd4, $urandom());
      end
    join
    sent = 0;
    while (sent < 410) begin
      nw = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 17);
      send_msg(nw, 3'($urandom_range(0, 7)), $urandom());
      sent += nw + 1;
    end
    drain();
    rx_done = 1'b1;
    repeat (200) @(posedge clk);
    if (board.err_cnt == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
